// ===== rtl/core/lrm_pkg.sv =====
// ----------------------------------------------------------------------------
// lrm_pkg: shared constants and types of the line regex matcher
// Character codes, register indexes and the compiler status bundle.
// ----------------------------------------------------------------------------
package lrm_pkg;

    localparam int MAX_PATTERN_DEF = 16;   // default pattern capacity
    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 64;   // widest configuration register
    localparam int CFG_IDX_W       = 2;
    localparam int LEN_W           = 5;    // pattern_length register

    // character codes
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CARET   = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    // compiler status seen by the datapath
    typedef struct packed {
        logic busy;          // compile pass running
        logic anchored;      // leading '^'
        logic end_anchored;  // trailing '$'
    } t_cmp_status;

endpackage

// ===== rtl/core/line_regex_matcher.sv =====
// ----------------------------------------------------------------------------
// line_regex_matcher: streaming line matcher for a small regex language
// Byte-in, flag-out matcher; one result per newline.
// ----------------------------------------------------------------------------
// Text bytes stream in at one byte per clock and each newline byte produces
// one transfer on the output: 1 if the line just ended contains a match of
// the programmed pattern. The pattern language is the classic tiny one:
// leading '^' anchors to line start, trailing '$' to line end, '.' matches
// any byte, "c*" is zero or more of c, and anything else (a leading '*'
// included) is literal. Zero bytes are accepted and dropped. The sustained
// rate is one byte per cycle, set by the update of the active position
// register between the input and result registers, unless a compile pass or
// a newline waiting on a full result register stalls the input. Every
// configuration write starts a compile pass that walks the pattern from a
// start state, a character or a starred pair per step, while the input side
// stalls; the match state of a line in progress is kept across it.
// ----------------------------------------------------------------------------
module line_regex_matcher #(
    parameter int MAX_PATTERN = lrm_pkg::MAX_PATTERN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrm_pkg::CFG_W-1:0]     i_cfg_data,
    // text input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lrm_pkg::BYTE_W-1:0]    i_in_text_byte,
    // match result
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_out_line_matched
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // input register
    logic                       r_in_valid;
    logic [lrm_pkg::BYTE_W-1:0] r_in_byte;
    // result register
    logic                       r_out_valid;
    logic                       r_out_matched;

    logic [lrm_pkg::BYTE_W-1:0] tok_ch [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     tok_star;
    logic [CNT_W-1:0]           tok_count;
    lrm_pkg::t_cmp_status       cmp_status;

    logic is_newline;
    logic is_zero;
    logic out_free;
    logic fire;
    logic line_matched;

    lrm_compiler #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_compiler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tok_ch    (tok_ch),
        .o_tok_star  (tok_star),
        .o_tok_count (tok_count),
        .o_status    (cmp_status)
    );

    assign is_newline = (r_in_byte == lrm_pkg::CH_NEWLINE);
    assign is_zero    = (r_in_byte == '0);

    // result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // the held byte is consumed once the token list is stable; a newline
    // also needs room in the result register
    assign fire = r_in_valid && !cmp_status.busy && (!is_newline || out_free);

    // input register refills in the same cycle it is consumed
    assign o_in_stall = cmp_status.busy || (r_in_valid && !fire);

    lrm_nfa #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_nfa (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (fire && !is_zero),
        .i_byte         (r_in_byte),
        .i_tok_ch       (tok_ch),
        .i_tok_star     (tok_star),
        .i_tok_count    (tok_count),
        .i_status       (cmp_status),
        .o_line_matched (line_matched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_in_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_newline) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_newline) begin
            r_out_matched <= line_matched;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_line_matched = r_out_matched;

endmodule

// ===== rtl/core/lrm_compiler.sv =====
// ----------------------------------------------------------------------------
// lrm_compiler: pattern registers and token compiler
// Holds the configuration registers and, after each write, walks the pattern
// a character, or a character with its star, per step to build the token list.
// ----------------------------------------------------------------------------
module lrm_compiler #(
    parameter int MAX_PATTERN = lrm_pkg::MAX_PATTERN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lrm_pkg::CFG_W-1:0]        i_cfg_data,
    output logic [lrm_pkg::BYTE_W-1:0]       o_tok_ch [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0]           o_tok_star,
    output logic [$clog2(MAX_PATTERN+1)-1:0] o_tok_count,
    output lrm_pkg::t_cmp_status             o_status
);

    localparam int IDX_W  = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {
        C_IDLE,
        C_START,
        C_SCAN
    } t_cstate;

    t_cstate                          r_state;
    logic [lrm_pkg::CFG_W-1:0]        r_pat_low;
    logic [lrm_pkg::CFG_W-1:0]        r_pat_high;
    logic [lrm_pkg::LEN_W-1:0]        r_pat_len;
    logic [IDX_W-1:0]                 r_idx;
    logic [IDX_W-1:0]                 r_count;
    logic                             r_anchored;
    logic                             r_end_anchored;
    logic [lrm_pkg::BYTE_W-1:0]       r_tok_ch [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]           r_tok_star;

    logic [2*lrm_pkg::CFG_W-1:0]      pat_flat;
    logic [lrm_pkg::BYTE_W-1:0]       c_arr [MAX_PATTERN];
    logic [IDX_W-1:0]                 len_raw;
    logic [IDX_W-1:0]                 idx_p1;
    logic [lrm_pkg::BYTE_W-1:0]       ci;
    logic [lrm_pkg::BYTE_W-1:0]       cn;
    logic                             cur_ok;
    logic                             has_next;
    logic                             star_next;
    logic                             last_char;
    logic                             anch_now;

    assign pat_flat = {r_pat_high, r_pat_low};

    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            c_arr[p] = pat_flat[p*lrm_pkg::BYTE_W +: lrm_pkg::BYTE_W];
        end
    end

    // lengths above capacity are clipped
    assign len_raw = (r_pat_len > lrm_pkg::LEN_W'(MAX_PATTERN)) ? IDX_W'(MAX_PATTERN)
                                                                 : r_pat_len[IDX_W-1:0];

    assign idx_p1    = r_idx + IDX_W'(1);
    assign ci        = (r_idx < len_raw) ? c_arr[r_idx[PIDX_W-1:0]] : '0;
    assign cur_ok    = (ci != '0);       // a zero character ends the pattern
    assign has_next  = (idx_p1 < len_raw);
    assign cn        = has_next ? c_arr[idx_p1[PIDX_W-1:0]] : '0;
    assign star_next = (cn == lrm_pkg::CH_STAR);
    assign last_char = (cn == '0);
    assign anch_now  = (len_raw != '0) && (c_arr[0] == lrm_pkg::CH_CARET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= C_IDLE;
            r_pat_low      <= '0;
            r_pat_high     <= '0;
            r_pat_len      <= '0;
            r_idx          <= '0;
            r_count        <= '0;
            r_anchored     <= 1'b0;
            r_end_anchored <= 1'b0;
            r_tok_star     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lrm_pkg::REG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                lrm_pkg::REG_PAT_HIGH: r_pat_high <= i_cfg_data;
                lrm_pkg::REG_PAT_LEN:  r_pat_len  <= i_cfg_data[lrm_pkg::LEN_W-1:0];
                default: ;
            endcase
            r_state <= C_START;
        end else begin
            case (r_state)
                C_IDLE: ;
                C_START: begin
                    r_anchored     <= anch_now;
                    r_end_anchored <= 1'b0;
                    r_idx          <= anch_now ? IDX_W'(1) : '0;
                    r_count        <= '0;
                    r_tok_star     <= '0;
                    r_state        <= C_SCAN;
                end
                C_SCAN: begin
                    if (!cur_ok) begin
                        r_state <= C_IDLE;
                    end else if (star_next) begin
                        r_tok_ch[r_count[PIDX_W-1:0]]   <= ci;
                        r_tok_star[r_count[PIDX_W-1:0]] <= 1'b1;
                        r_count <= r_count + IDX_W'(1);
                        r_idx   <= r_idx + IDX_W'(2);
                    end else if (ci == lrm_pkg::CH_DOLLAR && last_char) begin
                        r_end_anchored <= 1'b1;
                        r_idx          <= idx_p1;
                    end else begin
                        r_tok_ch[r_count[PIDX_W-1:0]] <= ci;
                        r_count <= r_count + IDX_W'(1);
                        r_idx   <= idx_p1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_tok_ch                = r_tok_ch;
    assign o_tok_star              = r_tok_star;
    assign o_tok_count             = r_count;
    assign o_status.busy           = (r_state != C_IDLE);
    assign o_status.anchored       = r_anchored;
    assign o_status.end_anchored   = r_end_anchored;

endmodule

// ===== rtl/core/lrm_nfa.sv =====
// ----------------------------------------------------------------------------
// lrm_nfa: bit-parallel match state
// Active token positions and line flags, advanced by one text byte per step.
// ----------------------------------------------------------------------------
module lrm_nfa #(
    parameter int MAX_PATTERN = lrm_pkg::MAX_PATTERN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [lrm_pkg::BYTE_W-1:0]       i_byte,
    input  logic [lrm_pkg::BYTE_W-1:0]       i_tok_ch [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0]           i_tok_star,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] i_tok_count,
    input  lrm_pkg::t_cmp_status             i_status,
    output logic                             o_line_matched
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN:0] r_active;
    logic                 r_found;
    logic                 r_at_start;

    logic [MAX_PATTERN:0] mask;
    logic [MAX_PATTERN:0] accept_hot;
    logic [MAX_PATTERN:0] entry_raw;
    logic [MAX_PATTERN:0] entry_set;
    logic [MAX_PATTERN:0] next_raw;
    logic [MAX_PATTERN:0] next_set;
    logic                 accept_now;
    logic                 accept_next;
    logic                 is_newline;

    // star tokens pass activity on to the following position; a carry-style chain
    function automatic logic [MAX_PATTERN:0] closure(input logic [MAX_PATTERN:0] s,
                                                     input logic [MAX_PATTERN-1:0] st);
        logic [MAX_PATTERN:0] c;
        c = s;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            c[k+1] = c[k+1] | (c[k] & st[k]);
        end
        return c;
    endfunction

    always_comb begin
        for (int j = 0; j <= MAX_PATTERN; j++) begin
            mask[j] = (CNT_W'(j) <= i_tok_count);
        end
    end

    assign accept_hot = {{MAX_PATTERN{1'b0}}, 1'b1} << i_tok_count;

    always_comb begin
        entry_raw    = r_active & mask;
        entry_raw[0] = entry_raw[0] | r_at_start | !i_status.anchored;
    end

    assign entry_set = closure(entry_raw, i_tok_star);

    always_comb begin
        next_raw = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (entry_set[k] && (CNT_W'(k) < i_tok_count) &&
                (i_tok_ch[k] == lrm_pkg::CH_DOT || i_tok_ch[k] == i_byte)) begin
                if (i_tok_star[k]) begin
                    next_raw[k] = 1'b1;
                end else begin
                    next_raw[k+1] = 1'b1;
                end
            end
        end
    end

    assign next_set    = closure(next_raw, i_tok_star);
    assign accept_now  = |(entry_set & accept_hot);
    assign accept_next = |(next_set & accept_hot);
    assign is_newline  = (i_byte == lrm_pkg::CH_NEWLINE);

    assign o_line_matched = r_found | accept_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_found    <= 1'b0;
            r_at_start <= 1'b1;
        end else if (i_step) begin
            if (is_newline) begin
                r_active   <= '0;
                r_found    <= 1'b0;
                r_at_start <= 1'b1;
            end else begin
                r_active   <= next_set;
                r_found    <= r_found | (!i_status.end_anchored & (accept_now | accept_next));
                r_at_start <= 1'b0;
            end
        end
    end

endmodule
